// File: src/spq_pkg.sv
package spq_pkg;

	// operation codes
	localparam logic [2:0] OP_ENQUEUE = 3'd0;
	localparam logic [2:0] OP_CANCEL  = 3'd1;
	localparam logic [2:0] OP_DROP    = 3'd2;
	localparam logic [2:0] OP_SERVE   = 3'd3;
	localparam logic [2:0] OP_RETURN  = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_NO_STOCK  = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	localparam int ID_W    = 16;
	localparam int PRIO_W  = 8;
	localparam int STOCK_W = 16;
	localparam int QCNT_W  = 5;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture the incoming word
		logic compare;  // register per-slot compare flags
		logic update;   // commit slot moves, counters and result
	} spq_cmd_t;

endpackage

// File: src/spq_ctrl.sv
module spq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output spq_pkg::spq_cmd_t cmd
);
	import spq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t state_q, state_nxt;
	logic   accept;

	// only the compare cycle blocks a new word; the update cycle overlaps
	assign busy   = (state_q == S_CMP);
	assign accept = start && !busy;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_nxt = S_CMP;
			S_CMP:  state_nxt = S_UPD;
			S_UPD:  state_nxt = start ? S_CMP : S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign cmd.load    = accept;
	assign cmd.compare = (state_q == S_CMP);
	assign cmd.update  = (state_q == S_UPD);

	a_cmp_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.compare |=> cmd.update)
		else $error("compare not followed by update");

	a_load_then_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.compare)
		else $error("accepted word not compared");

	a_upd_after_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $past(cmd.compare))
		else $error("update without compare");

endmodule

// File: src/spq_datapath.sv
module spq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spq_pkg::spq_cmd_t             cmd,
	input  logic [2:0]                    operation,
	input  logic [spq_pkg::ID_W-1:0]      requester_id,
	input  logic [spq_pkg::PRIO_W-1:0]    priority_req,
	input  logic                          cfg_we,
	input  logic [spq_pkg::STOCK_W-1:0]   cfg_wdata,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [spq_pkg::ID_W-1:0]      served_id,
	output logic [spq_pkg::STOCK_W-1:0]   stock_left,
	output logic [spq_pkg::QCNT_W-1:0]    queue_count
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	// captured word
	logic [2:0]        op_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;

	// slot cells, slot 0 is the head; contents past cnt_q are junk
	logic [ID_W-1:0]   slot_id_q  [DEPTH];
	logic [PRIO_W-1:0] slot_pri_q [DEPTH];

	logic [CW-1:0]      cnt_q, cnt_nxt;
	logic [STOCK_W-1:0] stock_q, stock_nxt;

	logic [DEPTH-1:0] gt_q;     // valid slot with priority value above the new one
	logic [DEPTH-1:0] match_q;  // valid slot holding the cancel id
	logic [DEPTH-1:0] hit_mask; // first match and everything behind it
	logic [DEPTH-1:0] rm_mask;
	logic             found;

	logic              do_ins, do_rm;
	logic [2:0]        st_nxt;
	logic [ID_W-1:0]   served_nxt;

	logic              done_q;
	logic [2:0]        status_q;
	logic [ID_W-1:0]   served_q;
	logic [31:0]       cnt_ext;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			id_q   <= requester_id;
			prio_q <= priority_req;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int k = 0; k < DEPTH; k++) begin
				gt_q[k]    <= (CW'(k) < cnt_q) && (slot_pri_q[k] > prio_q);
				match_q[k] <= (CW'(k) < cnt_q) && (slot_id_q[k] == id_q);
			end
		end
	end

	// x | -x sets the lowest set bit and all bits above it
	assign hit_mask = match_q | (~match_q + DEPTH'(1));
	assign found    = |match_q;

	always_comb begin
		do_ins     = 1'b0;
		do_rm      = 1'b0;
		rm_mask    = '1;
		st_nxt     = ST_OK;
		served_nxt = '0;
		stock_nxt  = stock_q;
		cnt_nxt    = cnt_q;
		unique case (op_q)
			OP_ENQUEUE: begin
				if (cnt_q == CW'(DEPTH)) begin
					st_nxt = ST_FULL;
				end else begin
					do_ins  = 1'b1;
					cnt_nxt = cnt_q + CW'(1);
				end
			end
			OP_CANCEL: begin
				if (cnt_q == '0) begin
					st_nxt = ST_EMPTY;
				end else if (!found) begin
					st_nxt = ST_NOT_FOUND;
				end else begin
					do_rm   = 1'b1;
					rm_mask = hit_mask;
					cnt_nxt = cnt_q - CW'(1);
				end
			end
			OP_DROP: begin
				if (cnt_q == '0) begin
					st_nxt = ST_EMPTY;
				end else begin
					do_rm      = 1'b1;
					served_nxt = slot_id_q[0];
					cnt_nxt    = cnt_q - CW'(1);
				end
			end
			OP_SERVE: begin
				if (cnt_q == '0) begin
					st_nxt = ST_EMPTY;
				end else if (stock_q == '0) begin
					st_nxt = ST_NO_STOCK;
				end else begin
					do_rm      = 1'b1;
					served_nxt = slot_id_q[0];
					stock_nxt  = stock_q - STOCK_W'(1);
					cnt_nxt    = cnt_q - CW'(1);
				end
			end
			OP_RETURN: begin
				if (stock_q != '1) stock_nxt = stock_q + STOCK_W'(1);
			end
			default: begin
			end
		endcase
	end

	// each cell picks from its neighbour, the new word, or holds
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic              from_prev, from_next, take_new;
		logic [ID_W-1:0]   prev_id, next_id;
		logic [PRIO_W-1:0] prev_pri, next_pri;

		if (g > 0) begin : g_prev
			assign from_prev = gt_q[g-1];
			assign prev_id   = slot_id_q[g-1];
			assign prev_pri  = slot_pri_q[g-1];
		end else begin : g_noprev
			assign from_prev = 1'b0;
			assign prev_id   = '0;
			assign prev_pri  = '0;
		end

		if (g < DEPTH - 1) begin : g_next
			assign from_next = rm_mask[g];
			assign next_id   = slot_id_q[g+1];
			assign next_pri  = slot_pri_q[g+1];
		end else begin : g_nonext
			assign from_next = 1'b0;
			assign next_id   = '0;
			assign next_pri  = '0;
		end

		assign take_new = gt_q[g] || (CW'(g) == cnt_q);

		always_ff @(posedge clk) begin
			if (cmd.update) begin
				priority if (do_ins && from_prev) begin
					slot_id_q[g]  <= prev_id;
					slot_pri_q[g] <= prev_pri;
				end else if (do_ins && take_new) begin
					slot_id_q[g]  <= id_q;
					slot_pri_q[g] <= prio_q;
				end else if (do_rm && from_next) begin
					slot_id_q[g]  <= next_id;
					slot_pri_q[g] <= next_pri;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			stock_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cmd.update) begin
				cnt_q   <= cnt_nxt;
				stock_q <= stock_nxt;
			end else if (cfg_we) begin
				stock_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			status_q <= st_nxt;
			served_q <= served_nxt;
		end
	end

	assign cnt_ext     = 32'(cnt_q);
	assign done        = done_q;
	assign status      = status_q;
	assign served_id   = served_q;
	assign stock_left  = stock_q;
	assign queue_count = cnt_ext[QCNT_W-1:0];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_full_at_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_FULL) |-> (cnt_q == CW'(DEPTH)))
		else $error("full reported below depth");

	a_served_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_OK) |-> (served_q == '0))
		else $error("served id on failed operation");

	// op_q may already hold the next word here, so look at the update cycle
	a_notfound_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_NOT_FOUND) |-> ($past(op_q) == OP_CANCEL))
		else $error("not found outside cancel");

endmodule

// File: src/stable_priority_queue_with_cancel.sv
// Stable priority queue of waiting requesters with a stock counter. Pulse
// start with operation, requester_id and priority_req while busy is low;
// the word is taken at that edge. Each word yields exactly one result word,
// shown for a single cycle with done high: status, served_id, stock_left and
// queue_count. The receiver cannot stall, so done must be sampled when it
// comes. After acceptance the parallel per-slot compares are registered, then
// every slot cell shifts at once and the result is registered; a new word may
// be accepted while the previous word shifts, but not during its compares.
// Lower priority values are served first; equal values keep arrival order.
// Writing cfg_we/cfg_wdata loads the stock count; do so only with the block
// idle. Slot contents have no reset; only the entry count, stock and done
// are cleared, stock to zero.
module stable_priority_queue_with_cancel #(
	parameter int QUEUE_DEPTH = 16   // 2 to 31 entries
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command word
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    operation,
	input  logic [spq_pkg::ID_W-1:0]      requester_id,
	input  logic [spq_pkg::PRIO_W-1:0]    priority_req,
	// stock register
	input  logic                          cfg_we,
	input  logic [spq_pkg::STOCK_W-1:0]   cfg_wdata,
	// result word
	output logic                          done,
	output logic [2:0]                    status,
	output logic [spq_pkg::ID_W-1:0]      served_id,
	output logic [spq_pkg::STOCK_W-1:0]   stock_left,
	output logic [spq_pkg::QCNT_W-1:0]    queue_count
);
	import spq_pkg::*;

	spq_cmd_t cmd;

	// sequencer: idle -> compare -> update, update overlapping the next load
	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// slot cells, counters and result registers
	spq_datapath #(
		.DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (operation),
		.requester_id (requester_id),
		.priority_req (priority_req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.status       (status),
		.served_id    (served_id),
		.stock_left   (stock_left),
		.queue_count  (queue_count)
	);

endmodule

// File: test/tb_top.sv
// Testbench for stable_priority_queue_with_cancel.
// A short table of hand-picked words runs first. Its rows cover the empty,
// not-found and no-stock statuses, the unused operation codes, ties in
// priority and stock saturation. Six random phases follow, each with its own
// stock load and one of three mixes of operations, so the queue fills,
// drains and churns in turn. A shadow copy of the queue and of the stock count
// predicts every result word. The monitor checks those words in order.
module tb_top;
	import spq_pkg::*;

	localparam int DEPTH = 16;
	localparam int PHASE_WORDS = 250;
	localparam int N_PHASES = 6;
	localparam int N_STEPS = 24;

	// codes 5 to 7 are decoded as no-ops by the block
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	// one result word as the block presents it
	typedef struct packed {
		logic [2:0]         status;
		logic [ID_W-1:0]    served;
		logic [STOCK_W-1:0] stock;
		logic [QCNT_W-1:0]  qcount;
	} result_t;

	// one waiting requester in the shadow queue
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// one row of the directed table; want is only used where typed is set
	typedef struct packed {
		logic               reload;
		logic [STOCK_W-1:0] reload_val;
		logic [2:0]         op;
		logic [ID_W-1:0]    id;
		logic [PRIO_W-1:0]  prio;
		logic               typed;
		result_t            want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] operation = OP_ENQUEUE;
	logic [ID_W-1:0] requester_id = '0;
	logic [PRIO_W-1:0] priority_req = '0;
	logic cfg_we = 1'b0;
	logic [STOCK_W-1:0] cfg_wdata = '0;
	logic done;
	logic [2:0] status;
	logic [ID_W-1:0] served_id;
	logic [STOCK_W-1:0] stock_left;
	logic [QCNT_W-1:0] queue_count;

	// shadow state: sorted waiting list (head at index 0) and stock count
	entry_t waiting[$];
	logic [STOCK_W-1:0] stock;

	result_t awaited_words[$];   // predicted words, oldest first
	result_t got_word;
	result_t want_word;
	int errors = 0;
	int words_seen = 0;
	int stock_loads = 0;
	int status_tally[5] = '{default: 0};
	bit gaps_on = 1'b1;

	step_t steps [N_STEPS] = '{
		// empty queue, stock zero straight out of reset
		{1'b0, 16'h0000, OP_SERVE,   16'h0000, 8'h00, 1'b1, {ST_EMPTY, 16'h0, 16'h0000, 5'd0}},
		{1'b0, 16'h0000, OP_DROP,    16'h0000, 8'h00, 1'b1, {ST_EMPTY, 16'h0, 16'h0000, 5'd0}},
		{1'b0, 16'h0000, OP_CANCEL,  16'hFFFF, 8'hFF, 1'b1, {ST_EMPTY, 16'h0, 16'h0000, 5'd0}},
		{1'b0, 16'h0000, OP_UNUSED_LO, 16'hFFFF, 8'hFF, 1'b1, {ST_OK, 16'h0, 16'h0000, 5'd0}},
		{1'b0, 16'h0000, OP_UNUSED_HI, 16'h0000, 8'h00, 1'b1, {ST_OK, 16'h0, 16'h0000, 5'd0}},
		// id and priority extremes, then ties at both ends of the range
		{1'b0, 16'h0000, OP_ENQUEUE, 16'hFFFF, 8'hFF, 1'b1, {ST_OK, 16'h0, 16'h0000, 5'd1}},
		{1'b0, 16'h0000, OP_ENQUEUE, 16'h0000, 8'h00, 1'b1, {ST_OK, 16'h0, 16'h0000, 5'd2}},
		{1'b0, 16'h0000, OP_ENQUEUE, 16'h1234, 8'hFF, 1'b0, result_t'(0)},
		{1'b0, 16'h0000, OP_ENQUEUE, 16'h5555, 8'h80, 1'b0, result_t'(0)},
		{1'b0, 16'h0000, OP_ENQUEUE, 16'h0AAA, 8'h00, 1'b0, result_t'(0)},
		{1'b0, 16'h0000, OP_CANCEL,  16'hBEEF, 8'h00, 1'b1, {ST_NOT_FOUND, 16'h0, 16'h0000, 5'd5}},
		{1'b0, 16'h0000, OP_SERVE,   16'h0000, 8'h00, 1'b1, {ST_NO_STOCK, 16'h0, 16'h0000, 5'd5}},
		{1'b0, 16'h0000, OP_RETURN,  16'h0000, 8'h00, 1'b1, {ST_OK, 16'h0, 16'h0001, 5'd5}},
		{1'b0, 16'h0000, OP_SERVE,   16'h0000, 8'h00, 1'b0, result_t'(0)},
		{1'b0, 16'h0000, OP_CANCEL,  16'h5555, 8'h00, 1'b0, result_t'(0)},
		{1'b0, 16'h0000, OP_DROP,    16'h0000, 8'h00, 1'b0, result_t'(0)},
		// stock at the top end: second return must saturate
		{1'b1, 16'hFFFE, OP_RETURN,  16'h0000, 8'h00, 1'b1, {ST_OK, 16'h0, 16'hFFFF, 5'd2}},
		{1'b0, 16'h0000, OP_RETURN,  16'h0000, 8'h00, 1'b1, {ST_OK, 16'h0, 16'hFFFF, 5'd2}},
		{1'b0, 16'h0000, OP_SERVE,   16'h0000, 8'h00, 1'b0, result_t'(0)},
		{1'b0, 16'h0000, OP_SERVE,   16'h0000, 8'h00, 1'b0, result_t'(0)},
		{1'b0, 16'h0000, OP_CANCEL,  16'h0000, 8'h00, 1'b1, {ST_EMPTY, 16'h0, 16'hFFFD, 5'd0}},
		// stock reloaded to zero, then an entry is enqueued and finds no stock
		{1'b1, 16'h0000, OP_ENQUEUE, 16'h8000, 8'h7F, 1'b0, result_t'(0)},
		{1'b0, 16'h0000, OP_SERVE,   16'h0000, 8'h00, 1'b1, {ST_NO_STOCK, 16'h0, 16'h0000, 5'd1}},
		{1'b0, 16'h0000, OP_DROP,    16'h0000, 8'h00, 1'b0, result_t'(0)}
	};

	stable_priority_queue_with_cancel #(
		.QUEUE_DEPTH (DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.requester_id (requester_id),
		.priority_req (priority_req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.status       (status),
		.served_id    (served_id),
		.stock_left   (stock_left),
		.queue_count  (queue_count)
	);

	always #5 clk = ~clk;

	// Shadow of the queue: works out the result word of one request and
	// moves the shadow state on. Ties keep arrival order, so a new entry goes
	// behind every entry of equal or lower priority value.
	task automatic apply_request(input logic [2:0] op, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] prio, output result_t r);
		int pos;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_ENQUEUE: begin
				if (waiting.size() >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < waiting.size() && waiting[pos].prio <= prio)
						pos++;
					waiting.insert(pos, entry_t'{id, prio});
				end
			end
			OP_CANCEL: begin
				if (waiting.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					pos = 0;
					while (pos < waiting.size() && waiting[pos].id != id)
						pos++;
					if (pos == waiting.size())
						r.status = ST_NOT_FOUND;
					else
						waiting.delete(pos);
				end
			end
			OP_DROP: begin
				if (waiting.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.served = waiting[0].id;
					waiting.delete(0);
				end
			end
			// empty is checked before stock
			OP_SERVE: begin
				if (waiting.size() == 0) begin
					r.status = ST_EMPTY;
				end else if (stock == '0) begin
					r.status = ST_NO_STOCK;
				end else begin
					r.served = waiting[0].id;
					stock--;
					waiting.delete(0);
				end
			end
			OP_RETURN: begin
				if (stock != '1)
					stock++;
			end
			default: begin
			end
		endcase
		r.stock = stock;
		r.qcount = QCNT_W'(waiting.size());
	endtask

	// Present one word and hold it until the block takes it; a typed
	// expectation overrides the shadow's, but the shadow still advances.
	task automatic send_word(input logic [2:0] op, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] prio, input logic typed, input result_t want);
		result_t predicted;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		requester_id <= id;
		priority_req <= prio;
		do
			@(posedge clk);
		while (busy);
		apply_request(op, id, prio, predicted);
		awaited_words.push_back(typed ? want : predicted);
	endtask

	// Stock register is only written with the block idle: start is dropped and
	// every awaited word comes back before the write.
	task automatic load_stock(input logic [STOCK_W-1:0] value);
		start <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		stock = value;
		stock_loads++;
	endtask

	// Random word for a phase. mode 0 fills, 1 drains, 2 churns with many
	// returns. Ids mostly come from a small pool or from the queue itself so
	// that cancels hit, duplicates occur and ties in priority are common.
	task automatic pick_word(input int mode, output logic [2:0] op,
			output logic [ID_W-1:0] id, output logic [PRIO_W-1:0] prio);
		int roll;
		int enq_pct;
		int cancel_pct;
		int drop_pct;
		int serve_pct;
		roll = $urandom_range(0, 99);
		case (mode)
			0: begin enq_pct = 55; cancel_pct = 70; drop_pct = 75; serve_pct = 85; end
			1: begin enq_pct = 25; cancel_pct = 40; drop_pct = 55; serve_pct = 85; end
			default: begin enq_pct = 40; cancel_pct = 55; drop_pct = 62; serve_pct = 80; end
		endcase
		if (roll < enq_pct)
			op = OP_ENQUEUE;
		else if (roll < cancel_pct)
			op = OP_CANCEL;
		else if (roll < drop_pct)
			op = OP_DROP;
		else if (roll < serve_pct)
			op = OP_SERVE;
		else if (roll < 96)
			op = OP_RETURN;
		else
			op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

		case ($urandom_range(0, 3))
			0, 1: id = ID_W'($urandom_range(0, 7));
			2: id = ID_W'($urandom);
			default: id = $urandom_range(0, 1) ? '1 : 16'h8000;
		endcase
		// cancels mostly aim at something that is waiting
		if (op == OP_CANCEL && waiting.size() != 0 && $urandom_range(0, 2) != 0)
			id = waiting[$urandom_range(0, waiting.size() - 1)].id;

		case ($urandom_range(0, 3))
			0, 1: prio = PRIO_W'($urandom_range(0, 3));
			2: prio = PRIO_W'($urandom);
			default: prio = $urandom_range(0, 1) ? '1 : '0;
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Result words cannot be held off, so every done cycle is checked here.
	always @(posedge clk) begin
		if (arst_n && done) begin
			got_word = {status, served_id, stock_left, queue_count};
			words_seen++;
			if (status < 3'd5)
				status_tally[status]++;
			if (awaited_words.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %0h", $time,
					got_word);
				errors++;
			end else begin
				want_word = awaited_words.pop_front();
				check_field("status", 16'(want_word.status), 16'(status));
				check_field("served_id", want_word.served, served_id);
				check_field("stock_left", want_word.stock, stock_left);
				check_field("queue_count", 16'(want_word.qcount), 16'(queue_count));
			end
		end
	end

	initial begin
		int idx;
		int ph;
		int n;
		logic [2:0] op;
		logic [ID_W-1:0] id;
		logic [PRIO_W-1:0] prio;
		logic [STOCK_W-1:0] phase_stock;

		// shadow matches the block after reset: nothing waiting, no stock
		waiting.delete();
		stock = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (idx = 0; idx < N_STEPS; idx++) begin
			if (steps[idx].reload)
				load_stock(steps[idx].reload_val);
			send_word(steps[idx].op, steps[idx].id, steps[idx].prio, steps[idx].typed,
				steps[idx].want);
		end

		// The phase plan walks the stock through small, zero, top-end and
		// random loads. Both churn phases, the second of them closing the run, run back to back.
		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: phase_stock = 16'd3;
				1: phase_stock = '0;
				2: phase_stock = '1;
				4: phase_stock = 16'd1;
				default: phase_stock = STOCK_W'($urandom);
			endcase
			load_stock(phase_stock);
			gaps_on = !(ph == 2 || ph == N_PHASES - 1);
			for (n = 0; n < PHASE_WORDS; n++) begin
				pick_word(ph % 3, op, id, prio);
				send_word(op, id, prio, 1'b0, result_t'(0));
			end
		end

		start <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("Checked %0d result words across %0d stock loads.", words_seen, stock_loads);
		$display("Status mix ok/empty/no-stock/not-found/full: %0d/%0d/%0d/%0d/%0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3],
			status_tally[4]);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#3000000;
		$display("%0t: timeout, %0d words still outstanding", $time, awaited_words.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/stable_priority_queue_with_cancel.sv
test/tb_top.sv
